@@ sv/biquad_iir_filter_with_gains_defines.svh @@
// Assertion macros for the biquad filter block.
// Plain text header, no dependencies; included by the top level.
`ifndef BIQUAD_IIR_FILTER_WITH_GAINS_DEFINES_SVH
`define BIQUAD_IIR_FILTER_WITH_GAINS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BQF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bqf assertion failed");

// Next-cycle implication, disabled during reset.
`define BQF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bqf assertion failed");

`endif

@@ sv/bqf_pkg.sv @@
// Shared constants, register indexes and controller/datapath types for the
// biquad filter block. No dependencies.
package bqf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 32;
    localparam int STATE_WIDTH  = 32;
    localparam int STATE_FRAC   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OG = 3'd6;

    localparam logic signed [CFG_DATA_W-1:0] RST_B0 = 32'sd536870912;
    localparam logic signed [CFG_DATA_W-1:0] RST_B1 = 32'sd1073741824;
    localparam logic signed [CFG_DATA_W-1:0] RST_B2 = 32'sd536870912;
    localparam logic signed [CFG_DATA_W-1:0] RST_A1 = -32'sd1057840781;
    localparam logic signed [CFG_DATA_W-1:0] RST_A2 = 32'sd521202334;
    localparam logic signed [CFG_DATA_W-1:0] RST_IG = 32'sd57982;
    localparam logic signed [CFG_DATA_W-1:0] RST_OG = 32'sd536870912;

    // Operand pair for the shared multiplier
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_X  = 3'd0;  // sample * input_gain
    localparam t_mul_sel MUL_B0 = 3'd1;  // b0 * x
    localparam t_mul_sel MUL_B1 = 3'd2;  // b1 * prev_in_1
    localparam t_mul_sel MUL_B2 = 3'd3;  // b2 * prev_in_2
    localparam t_mul_sel MUL_A1 = 3'd4;  // a1 * prev_out_1
    localparam t_mul_sel MUL_A2 = 3'd5;  // a2 * prev_out_2
    localparam t_mul_sel MUL_G  = 3'd6;  // s * output_gain

    typedef logic [1:0] t_acc_op;
    localparam t_acc_op ACC_HOLD = 2'd0;
    localparam t_acc_op ACC_LOAD = 2'd1;
    localparam t_acc_op ACC_ADD  = 2'd2;
    localparam t_acc_op ACC_SUB  = 2'd3;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     x_load;
        logic     s_load;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

@@ sv/bqf_ifs.sv @@
// Channel interfaces of the biquad filter block: sample in, result out and
// configuration write. Depends on bqf_pkg for default widths.
interface bqf_sample_if #(
    parameter int W = bqf_pkg::SAMPLE_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bqf_result_if #(
    parameter int W = bqf_pkg::SAMPLE_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered_sample;
    logic                saturated;

    modport source (output valid, output filtered_sample, output saturated, input ready);
    modport sink   (input valid, input filtered_sample, input saturated, output ready);
endinterface

interface bqf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bqf_pkg::CFG_IDX_W-1:0]       index;
    logic [bqf_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/bqf_datapath.sv @@
// Datapath of the biquad filter: coefficient registers, shared multiplier,
// wide accumulator, rounding/saturation, filter state and output register.
// Depends on bqf_pkg.
module bqf_datapath #(
    parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bqf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  bqf_pkg::t_cmd                       i_cmd,
    output bqf_pkg::t_stat                      o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_sample,
    output logic                                o_saturated
);

    localparam int STW  = bqf_pkg::STATE_WIDTH;
    localparam int CW   = COEF_WIDTH;
    localparam int SW   = SAMPLE_WIDTH;
    localparam int CF   = CW - 3;
    localparam int PW   = CW + STW;
    localparam int AW   = PW + 3;
    localparam int WW   = AW + 1;
    localparam int ISH  = CF + SW - 1 - bqf_pkg::STATE_FRAC;
    localparam int OSH  = (SW <= bqf_pkg::STATE_FRAC + 1) ? bqf_pkg::STATE_FRAC + 1 - SW : 0;
    localparam int LSH  = (SW >  bqf_pkg::STATE_FRAC + 1) ? SW - bqf_pkg::STATE_FRAC - 1 : 0;
    localparam int OW   = STW + 8;

    localparam logic signed [WW-1:0] X_HALF = (WW'(1) << ISH) >> 1;
    localparam logic signed [WW-1:0] C_HALF = (WW'(1) << CF) >> 1;
    localparam logic signed [OW-1:0] O_HALF = (OW'(1) << OSH) >> 1;

    // Clamp a wide value to the state range; top bit flags a clip
    function automatic logic [STW:0] sat_st(input logic signed [WW-1:0] v);
        logic [WW-STW:0] top;
        top = v[WW-1:STW-1];
        if (!v[WW-1] && (|top)) begin
            return {1'b1, 1'b0, {(STW-1){1'b1}}};
        end else if (v[WW-1] && !(&top)) begin
            return {1'b1, 1'b1, {(STW-1){1'b0}}};
        end else begin
            return {1'b0, v[STW-1:0]};
        end
    endfunction

    logic signed [CW-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2, r_ig, r_og;
    logic signed [STW-1:0] r_pin1, r_pin2, r_pout1, r_pout2;
    logic signed [STW-1:0] r_x, r_s;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic                  r_flag;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out_sample;
    logic                  r_out_sat;

    logic signed [CW-1:0]  w_mul_a;
    logic signed [STW-1:0] w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [WW-1:0]  w_x_wide, w_s_wide, w_y_wide;
    logic                  w_x_clip, w_s_clip, w_y_clip, w_o_clip;
    logic signed [STW-1:0] w_x, w_s, w_y;
    logic signed [OW-1:0]  w_y_ext, w_o_wide;
    logic [OW-SW:0]        w_o_top;
    logic signed [SW-1:0]  w_o;

    always_comb begin
        case (i_cmd.mul_sel)
            bqf_pkg::MUL_X: begin
                w_mul_a = r_ig;
                w_mul_b = STW'(i_sample);
            end
            bqf_pkg::MUL_B0: begin
                w_mul_a = r_b0;
                w_mul_b = r_x;
            end
            bqf_pkg::MUL_B1: begin
                w_mul_a = r_b1;
                w_mul_b = r_pin1;
            end
            bqf_pkg::MUL_B2: begin
                w_mul_a = r_b2;
                w_mul_b = r_pin2;
            end
            bqf_pkg::MUL_A1: begin
                w_mul_a = r_a1;
                w_mul_b = r_pout1;
            end
            bqf_pkg::MUL_A2: begin
                w_mul_a = r_a2;
                w_mul_b = r_pout2;
            end
            bqf_pkg::MUL_G: begin
                w_mul_a = r_og;
                w_mul_b = r_s;
            end
            default: begin
                w_mul_a = r_ig;
                w_mul_b = STW'(i_sample);
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    // Round half up, then clamp to the state range
    assign w_x_wide = (WW'(r_prod) + X_HALF) >>> ISH;
    assign w_s_wide = (WW'(r_acc) + C_HALF) >>> CF;
    assign w_y_wide = (WW'(r_prod) + C_HALF) >>> CF;
    assign {w_x_clip, w_x} = sat_st(w_x_wide);
    assign {w_s_clip, w_s} = sat_st(w_s_wide);
    assign {w_y_clip, w_y} = sat_st(w_y_wide);

    // Reduce y to sample format: round half up for narrow samples, shift up for wide
    assign w_y_ext  = OW'(w_y);
    assign w_o_wide = ((w_y_ext + O_HALF) >>> OSH) <<< LSH;
    assign w_o_top  = w_o_wide[OW-1:SW-1];

    always_comb begin
        if (!w_o_wide[OW-1] && (|w_o_top)) begin
            w_o_clip = 1'b1;
            w_o      = {1'b0, {(SW-1){1'b1}}};
        end else if (w_o_wide[OW-1] && !(&w_o_top)) begin
            w_o_clip = 1'b1;
            w_o      = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_o_clip = 1'b0;
            w_o      = w_o_wide[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0        <= CW'(bqf_pkg::RST_B0);
            r_b1        <= CW'(bqf_pkg::RST_B1);
            r_b2        <= CW'(bqf_pkg::RST_B2);
            r_a1        <= CW'(bqf_pkg::RST_A1);
            r_a2        <= CW'(bqf_pkg::RST_A2);
            r_ig        <= CW'(bqf_pkg::RST_IG);
            r_og        <= CW'(bqf_pkg::RST_OG);
            r_pin1      <= '0;
            r_pin2      <= '0;
            r_pout1     <= '0;
            r_pout2     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bqf_pkg::REG_B0: r_b0 <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_B1: r_b1 <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_B2: r_b2 <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_A1: r_a1 <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_A2: r_a2 <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_IG: r_ig <= i_cfg_data[CW-1:0];
                    bqf_pkg::REG_OG: r_og <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_pin2      <= r_pin1;
                r_pin1      <= r_x;
                r_pout2     <= r_pout1;
                r_pout1     <= w_y;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.acc_op)
            bqf_pkg::ACC_LOAD: r_acc <= AW'(r_prod);
            bqf_pkg::ACC_ADD:  r_acc <= r_acc + AW'(r_prod);
            bqf_pkg::ACC_SUB:  r_acc <= r_acc - AW'(r_prod);
            default: ;
        endcase
        if (i_cmd.x_load) begin
            r_x    <= w_x;
            r_flag <= w_x_clip;
        end
        if (i_cmd.s_load) begin
            r_s    <= w_s;
            r_flag <= r_flag | w_s_clip;
        end
        if (i_cmd.out_load) begin
            r_out_sample <= w_o;
            r_out_sat    <= r_flag | w_y_clip | w_o_clip;
        end
    end

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_saturated       = r_out_sat;

endmodule

@@ sv/bqf_ctrl.sv @@
// Sequencer of the biquad filter: steps the shared multiplier and the
// accumulator through one sample. Depends on bqf_pkg.
module bqf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bqf_pkg::t_stat i_stat,
    output bqf_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MB1  = 4'd1;
    localparam logic [3:0] ST_MB0  = 4'd2;
    localparam logic [3:0] ST_MB2  = 4'd3;
    localparam logic [3:0] ST_MA1  = 4'd4;
    localparam logic [3:0] ST_MA2  = 4'd5;
    localparam logic [3:0] ST_MSUM = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_MG   = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.mul_sel  = bqf_pkg::MUL_X;
        o_cmd.acc_op   = bqf_pkg::ACC_HOLD;
        o_cmd.x_load   = 1'b0;
        o_cmd.s_load   = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // sample * input_gain is captured on the accepting edge
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_MB1;
                end
            end
            ST_MB1: begin
                o_cmd.x_load  = 1'b1;
                o_cmd.mul_sel = bqf_pkg::MUL_B1;
                n_state       = ST_MB0;
            end
            ST_MB0: begin
                o_cmd.mul_sel = bqf_pkg::MUL_B0;
                o_cmd.acc_op  = bqf_pkg::ACC_LOAD;
                n_state       = ST_MB2;
            end
            ST_MB2: begin
                o_cmd.mul_sel = bqf_pkg::MUL_B2;
                o_cmd.acc_op  = bqf_pkg::ACC_ADD;
                n_state       = ST_MA1;
            end
            ST_MA1: begin
                o_cmd.mul_sel = bqf_pkg::MUL_A1;
                o_cmd.acc_op  = bqf_pkg::ACC_ADD;
                n_state       = ST_MA2;
            end
            ST_MA2: begin
                o_cmd.mul_sel = bqf_pkg::MUL_A2;
                o_cmd.acc_op  = bqf_pkg::ACC_SUB;
                n_state       = ST_MSUM;
            end
            ST_MSUM: begin
                o_cmd.acc_op = bqf_pkg::ACC_SUB;
                n_state      = ST_RND;
            end
            ST_RND: begin
                o_cmd.s_load = 1'b1;
                n_state      = ST_MG;
            end
            ST_MG: begin
                o_cmd.mul_sel = bqf_pkg::MUL_G;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // keep the gain product alive while the output slot is full
                o_cmd.mul_sel = bqf_pkg::MUL_G;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/biquad_iir_filter_with_gains.sv @@
// Top level of the biquad filter with input and output gains (direct form I).
// Depends on bqf_pkg, bqf_ifs, bqf_ctrl, bqf_datapath and the defines header.
//
//   channel  dir  payload                          transaction when
//   i_in     in   sample                           i_in.valid & i_in.ready
//   o_out    out  filtered_sample, saturated       o_out.valid & o_out.ready
//   i_cfg    in   index, data (7 registers)        i_cfg.valid & i_cfg.ready
//
// After its sample transaction a result steps through the sequencer states
// MB1, MB0, MB2, MA1, MA2, MSUM, RND, MG and OUT; one shared 32x32 multiplier
// does all seven products in sequence, the sum rounded before the output gain.
// Reset (synchronous) restores the default coefficients and clears the filter
// history. A new sample is taken as soon as the sequencer is idle, even while
// a result still waits; a stalled output holds the next result in its final
// step. Configuration is always ready.
`include "biquad_iir_filter_with_gains_defines.svh"

module biquad_iir_filter_with_gains #(
    parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bqf_sample_if.sink    i_in,
    bqf_result_if.source  o_out,
    bqf_cfg_if.sink       i_cfg
);

    bqf_pkg::t_cmd  w_cmd;
    bqf_pkg::t_stat w_stat;
    logic           w_in_ready;

    bqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bqf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_sample          (i_in.sample),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_filtered_sample (o_out.filtered_sample),
        .o_saturated       (o_out.saturated)
    );

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    `BQF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready && w_cmd.x_load)
    `BQF_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, w_stat.out_free)
    `BQF_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.out_load, o_out.valid)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for biquad_iir_filter_with_gains: streams samples,
// predicts every filtered result in fixed point and checks it field by field.
// Depends on bqf_pkg, the bqf_ifs channel interfaces and the block's RTL.
module testbench;

    localparam int          SAMPLE_WIDTH   = bqf_pkg::SAMPLE_WIDTH;
    localparam int          COEF_WIDTH     = bqf_pkg::COEF_WIDTH;
    localparam int          STATE_WIDTH    = bqf_pkg::STATE_WIDTH;
    localparam int          STATE_FRAC     = bqf_pkg::STATE_FRAC;
    localparam int          CFG_IDX_W      = bqf_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W     = bqf_pkg::CFG_DATA_W;
    localparam int          COEF_FRAC      = COEF_WIDTH - 3;
    localparam int          SAMPLE_LATENCY = 10;
    localparam int unsigned CYCLE_LIMIT    = 400_000;
    localparam int          SEGMENT_ITEMS  = 56;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef logic signed [71:0] t_wide;

    localparam t_wide STATE_MAX = (t_wide'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam t_wide STATE_MIN = -(t_wide'(1) <<< (STATE_WIDTH - 1));

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic signed [CFG_DATA_W-1:0] COEF_MAX = {1'b0, {(CFG_DATA_W-1){1'b1}}};
    localparam logic signed [CFG_DATA_W-1:0] COEF_MIN = {1'b1, {(CFG_DATA_W-1){1'b0}}};
    localparam logic signed [CFG_DATA_W-1:0] COEF_ONE = 32'sd536870912;

    typedef enum int {CFG_RESET, CFG_STABLE, CFG_RANDOM, CFG_EXTREME} t_cfg_mode;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
        logic                           saturated;
    } t_filter_out;

    typedef logic signed [CFG_DATA_W-1:0] t_coef_set [0:6];

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqf_sample_if sample_ch ();
    bqf_result_if result_ch ();
    bqf_cfg_if    cfg_ch ();

    biquad_iir_filter_with_gains u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the register file and filter history
    t_coef_set                     reg_image;
    logic signed [STATE_WIDTH-1:0] hist_x1, hist_x2, hist_y1, hist_y2;

    t_filter_out pending_outputs[$];
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;

    function automatic t_wide round_shr(t_wide v, int n);
        if (n == 0) return v;
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide clip(t_wide v, t_wide lo, t_wide hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic clips(t_wide v, t_wide lo, t_wide hi);
        return (v > hi) || (v < lo);
    endfunction

    // One filter step: scale, direct form I sum, output gain, sample rounding
    function automatic t_filter_out filter_step(logic signed [SAMPLE_WIDTH-1:0] smp);
        t_wide       x, acc, s, y, o;
        logic        hit;
        t_filter_out r;
        hit = 1'b0;
        x = round_shr(t_wide'(smp) * t_wide'(reg_image[bqf_pkg::REG_IG]),
                      COEF_FRAC + SAMPLE_WIDTH - 1 - STATE_FRAC);
        hit |= clips(x, STATE_MIN, STATE_MAX);
        x = clip(x, STATE_MIN, STATE_MAX);
        acc = t_wide'(reg_image[bqf_pkg::REG_B0]) * x
            + t_wide'(reg_image[bqf_pkg::REG_B1]) * t_wide'(hist_x1)
            + t_wide'(reg_image[bqf_pkg::REG_B2]) * t_wide'(hist_x2)
            - t_wide'(reg_image[bqf_pkg::REG_A1]) * t_wide'(hist_y1)
            - t_wide'(reg_image[bqf_pkg::REG_A2]) * t_wide'(hist_y2);
        s = round_shr(acc, COEF_FRAC);
        hit |= clips(s, STATE_MIN, STATE_MAX);
        s = clip(s, STATE_MIN, STATE_MAX);
        y = round_shr(s * t_wide'(reg_image[bqf_pkg::REG_OG]), COEF_FRAC);
        hit |= clips(y, STATE_MIN, STATE_MAX);
        y = clip(y, STATE_MIN, STATE_MAX);
        hist_x2 = hist_x1;
        hist_x1 = x[STATE_WIDTH-1:0];
        hist_y2 = hist_y1;
        hist_y1 = y[STATE_WIDTH-1:0];
        o = round_shr(y, STATE_FRAC + 1 - SAMPLE_WIDTH);
        hit |= clips(o, t_wide'(SAMPLE_BOT), t_wide'(SAMPLE_TOP));
        o = clip(o, t_wide'(SAMPLE_BOT), t_wide'(SAMPLE_TOP));
        r.filtered_sample = o[SAMPLE_WIDTH-1:0];
        r.saturated       = hit;
        return r;
    endfunction

    function automatic logic signed [CFG_DATA_W-1:0] span(longint lim);
        return CFG_DATA_W'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
    endfunction

    function automatic logic signed [CFG_DATA_W-1:0] extreme_coef();
        case ($urandom_range(0, 5))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return COEF_ONE;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample(
        logic signed [SAMPLE_WIDTH-1:0] prev
    );
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return SAMPLE_WIDTH'($urandom);
        if (pick == 5) return $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOT;
        // hold the last value to build steps the filter can settle on
        if (pick < 8) return prev;
        return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
    endfunction

    // Present one sample after a random gap; predict it on its transaction
    task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        pending_outputs.push_back(filter_step(value));
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx <= bqf_pkg::REG_OG) reg_image[idx] = value;
    endtask

    task automatic load_regs(input t_coef_set vals);
        for (int i = bqf_pkg::REG_B0; i <= bqf_pkg::REG_OG; i++) begin
            write_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_filter(input t_cfg_mode mode);
        t_coef_set                    vals;
        logic signed [CFG_DATA_W-1:0] a2;
        case (mode)
            CFG_RESET: begin
                vals = '{bqf_pkg::RST_B0, bqf_pkg::RST_B1, bqf_pkg::RST_B2,
                         bqf_pkg::RST_A1, bqf_pkg::RST_A2, bqf_pkg::RST_IG,
                         bqf_pkg::RST_OG};
            end
            CFG_STABLE: begin
                // keep poles inside the unit circle so the state stays off the rails
                a2 = $urandom_range(0, 400_000_000);
                vals[bqf_pkg::REG_B0] = span(536_870_912);
                vals[bqf_pkg::REG_B1] = span(536_870_912);
                vals[bqf_pkg::REG_B2] = span(536_870_912);
                vals[bqf_pkg::REG_A1] = span(longint'(536_870_912) + a2 - 67_108_864);
                vals[bqf_pkg::REG_A2] = a2;
                vals[bqf_pkg::REG_IG] = span(536_870_912);
                vals[bqf_pkg::REG_OG] = span(1_073_741_824);
            end
            CFG_RANDOM: begin
                for (int i = bqf_pkg::REG_B0; i <= bqf_pkg::REG_OG; i++) vals[i] = $urandom;
            end
            default: begin
                for (int i = bqf_pkg::REG_B0; i <= bqf_pkg::REG_OG; i++) begin
                    vals[i] = extreme_coef();
                end
            end
        endcase
        load_regs(vals);
    endtask

    task automatic test_reset_defaults();
        push_sample('0);
        push_sample(SAMPLE_TOP);
        push_sample(SAMPLE_TOP);
        push_sample(SAMPLE_BOT);
        push_sample(SAMPLE_BOT);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample('0);
    endtask

    // Maximum gains and positive feedback: the output sample clips first,
    // then the filter sum and the output gain stage run into the rails
    task automatic test_saturation_paths();
        wait_drained();
        load_regs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX});
        repeat (4) push_sample(SAMPLE_TOP);
        repeat (4) push_sample(SAMPLE_BOT);
    endtask

    task automatic test_unknown_register();
        wait_drained();
        write_reg(REG_UNUSED, $urandom);
        cfg_ch.valid <= 1'b0;
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        push_sample('0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int first_mode);
        logic signed [SAMPLE_WIDTH-1:0] smp;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        smp = '0;
        for (int seg = 0; seg < 2; seg++) begin
            // hold off until the block has delivered everything, then retune
            wait_drained();
            program_filter(t_cfg_mode'((first_mode + seg) % 4));
            repeat (SEGMENT_ITEMS) begin
                smp = next_sample(smp);
                push_sample(smp);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_filter_out want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_outputs.size() == 0) begin
                    $error("filtered_sample: expected none, actual %0d",
                           result_ch.filtered_sample);
                    mismatch_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (result_ch.filtered_sample !== want.filtered_sample) begin
                        $error("filtered_sample: expected %0d, actual %0d",
                               want.filtered_sample, result_ch.filtered_sample);
                        mismatch_count++;
                    end
                    if (result_ch.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, result_ch.saturated);
                        mismatch_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        reg_image = '{bqf_pkg::RST_B0, bqf_pkg::RST_B1, bqf_pkg::RST_B2,
                      bqf_pkg::RST_A1, bqf_pkg::RST_A2, bqf_pkg::RST_IG,
                      bqf_pkg::RST_OG};
        hist_x1 = '0;
        hist_x2 = '0;
        hist_y1 = '0;
        hist_y2 = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation_paths();
        test_unknown_register();
        test_random_traffic(0, 0, CFG_RESET);
        test_random_traffic(65, 0, CFG_RANDOM);
        test_random_traffic(0, 65, CFG_RESET);
        test_random_traffic(35, 35, CFG_RANDOM);

        wait_drained();
        repeat (3 * SAMPLE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+sv
sv/bqf_pkg.sv
sv/bqf_ifs.sv
sv/bqf_datapath.sv
sv/bqf_ctrl.sv
sv/biquad_iir_filter_with_gains.sv
tb/testbench.sv
